@@ rtl/sc1a_pkg.sv @@
// shared types, scan codes and letter tables for the set 1 to ascii translator
package sc1a_pkg;

	localparam int CODE_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int TDATA_W = 16;

	// pressed codes with a special role, and the break bit and release code range
	localparam logic [CODE_W-1:0] SC_LSHIFT   = 8'h2A;
	localparam logic [CODE_W-1:0] SC_RSHIFT   = 8'h36;
	localparam logic [CODE_W-1:0] SC_CAPSLOCK = 8'h3A;
	localparam logic [CODE_W-1:0] SC_TAB      = 8'h0F;
	localparam logic [CODE_W-1:0] SC_BACKSP   = 8'h0E;
	localparam logic [CODE_W-1:0] SC_SPACE    = 8'h39;
	localparam logic [CODE_W-1:0] SC_ZERO     = 8'h0B;
	localparam logic [CODE_W-1:0] SC_BREAK    = 8'h80;
	localparam logic [CODE_W-1:0] SC_REL_LO   = 8'h81;
	localparam logic [CODE_W-1:0] SC_REL_HI   = 8'hD8;

	// first and last code of each key group
	localparam logic [CODE_W-1:0] SC_DIG_LO = 8'h02;
	localparam logic [CODE_W-1:0] SC_DIG_HI = 8'h0A;
	localparam logic [CODE_W-1:0] SC_TOP_LO = 8'h10;
	localparam logic [CODE_W-1:0] SC_TOP_HI = 8'h19;
	localparam logic [CODE_W-1:0] SC_MID_LO = 8'h1E;
	localparam logic [CODE_W-1:0] SC_MID_HI = 8'h26;
	localparam logic [CODE_W-1:0] SC_LOW_LO = 8'h2C;
	localparam logic [CODE_W-1:0] SC_LOW_HI = 8'h32;

	localparam logic [CHAR_W-1:0] DIGIT_OFS = 7'd47;
	localparam logic [CHAR_W-1:0] CH_NONE   = 7'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CH_TAB    = 7'h09;
	localparam logic [CHAR_W-1:0] CH_BS     = 7'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
	localparam logic [CHAR_W-1:0] CH_LC_A   = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z   = 7'h7A;
	localparam logic [CHAR_W-1:0] CH_UC_A   = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z   = 7'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFS  = 7'h20;

	localparam logic [CHAR_W-1:0] ROW_TOP [10] = '{
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70
	};
	localparam logic [CHAR_W-1:0] ROW_MID [9] = '{
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C
	};
	localparam logic [CHAR_W-1:0] ROW_LOW [7] = '{
		7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D
	};

	// what one byte means, before the modifier state is applied
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              shift_press;
		logic              shift_release;
		logic              caps_press;
	} dec_t;

	typedef struct packed {
		logic shift;
		logic caps;
	} mods_t;

endpackage

@@ rtl/sc1a_decode.sv @@
// byte decode: lower-case character and modifier events of one scan code
module sc1a_decode (
	input  logic [sc1a_pkg::CODE_W-1:0] code,
	output sc1a_pkg::dec_t              dec
);
	import sc1a_pkg::*;

	logic       is_release;
	logic [3:0] top_idx;
	logic [3:0] mid_idx;
	logic [2:0] low_idx;
	logic [CODE_W-1:0] top_ofs;
	logic [CODE_W-1:0] mid_ofs;
	logic [CODE_W-1:0] low_ofs;

	assign is_release = (code >= SC_REL_LO) && (code <= SC_REL_HI);
	assign top_ofs = code - SC_TOP_LO;
	assign mid_ofs = code - SC_MID_LO;
	assign low_ofs = code - SC_LOW_LO;
	assign top_idx = top_ofs[3:0];
	assign mid_idx = mid_ofs[3:0];
	assign low_idx = low_ofs[2:0];

	always_comb begin
		dec = '0;
		if (is_release) begin
			dec.shift_release = ((code ^ SC_BREAK) == SC_LSHIFT) ||
			                    ((code ^ SC_BREAK) == SC_RSHIFT);
		end else begin
			dec.shift_press = (code == SC_LSHIFT) || (code == SC_RSHIFT);
			dec.caps_press  = (code == SC_CAPSLOCK);
			priority if (code >= SC_DIG_LO && code <= SC_DIG_HI) begin
				dec.ch = code[CHAR_W-1:0] + DIGIT_OFS;
			end else if (code == SC_ZERO) begin
				dec.ch = CH_ZERO;
			end else if (code >= SC_TOP_LO && code <= SC_TOP_HI) begin
				dec.ch = ROW_TOP[top_idx];
			end else if (code >= SC_MID_LO && code <= SC_MID_HI) begin
				dec.ch = ROW_MID[mid_idx];
			end else if (code >= SC_LOW_LO && code <= SC_LOW_HI) begin
				dec.ch = ROW_LOW[low_idx];
			end else if (code == SC_TAB) begin
				dec.ch = CH_TAB;
			end else if (code == SC_BACKSP) begin
				dec.ch = CH_BS;
			end else if (code == SC_SPACE) begin
				dec.ch = CH_SPACE;
			end else begin
				dec.ch = CH_NONE;
			end
		end
	end

endmodule

@@ rtl/sc1a_mods.sv @@
// shift and caps lock state, and the letter case that follows from it
module sc1a_mods (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  sc1a_pkg::dec_t              dec,
	output sc1a_pkg::mods_t             mods_nxt,
	output logic [sc1a_pkg::CHAR_W-1:0] ascii
);
	import sc1a_pkg::*;

	mods_t mods_q;
	logic  is_lower;

	always_comb begin
		mods_nxt = mods_q;
		if (dec.shift_press) begin
			mods_nxt.shift = 1'b1;
		end
		if (dec.shift_release) begin
			mods_nxt.shift = 1'b0;
		end
		if (dec.caps_press) begin
			mods_nxt.caps = ~mods_q.caps;
		end
	end

	// case is judged on the state after this byte
	assign is_lower = (dec.ch >= CH_LC_A) && (dec.ch <= CH_LC_Z);
	assign ascii = (is_lower && (mods_nxt.shift != mods_nxt.caps)) ? dec.ch - CASE_OFS
	                                                               : dec.ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
		end else if (adv) begin
			mods_q <= mods_nxt;
		end
	end

endmodule

@@ rtl/scan_code_set1_to_ascii_core.sv @@
// top level of the scan code set 1 to ascii translator
//
// channel  dir  tdata bits (low first)                        accept
// s_axis   in   [7:0] scan_code                               tvalid & tready
// m_axis   out  [6:0] ascii_char, [7] shift_held,             tvalid & tready
//               [8] caps_lock_on, [15:9] zero
//
// one item per cycle sustained while m_axis_tready stays high; m_axis_tvalid rises once
// the accepted byte has passed through the stage 1 and stage 2 registers
// stage 1 registers the byte, stage 2 registers the decoded result
// modifier state advances when a byte moves from stage 1 to stage 2
// arst_n clears both valid flags, shift and caps lock
// a stalled m_axis holds its result; stage 1 keeps taking a byte until both fill
module scan_code_set1_to_ascii_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] scan_code
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [sc1a_pkg::TDATA_W-1:0] m_axis_tdata    // ascii_char, shift, caps, pad
);
	import sc1a_pkg::*;

	// stage 1: raw byte
	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	// stage 2: finished result
	logic              valid_s2;
	logic [CHAR_W-1:0] ascii_s2;
	mods_t             mods_s2;

	logic              adv_s2;     // stage 1 moves into stage 2
	logic              take_s1;    // byte accepted into stage 1
	dec_t              dec;
	mods_t             mods_nxt;
	logic [CHAR_W-1:0] ascii_nxt;

	assign adv_s2        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign take_s1       = s_axis_tvalid && s_axis_tready;

	sc1a_decode u_decode (
		.code (code_s1),
		.dec  (dec)
	);

	sc1a_mods u_mods (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv_s2),
		.dec      (dec),
		.mods_nxt (mods_nxt),
		.ascii    (ascii_nxt)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (take_s1) begin
			code_s1 <= s_axis_tdata;
		end
		if (adv_s2) begin
			ascii_s2 <= ascii_nxt;
			mods_s2  <= mods_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(TDATA_W - CHAR_W - 2){1'b0}}, mods_s2.caps, mods_s2.shift,
	                        ascii_s2};

	// an upper-case letter only leaves when exactly one modifier is active
	a_upper_needs_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ascii_s2 >= CH_UC_A && ascii_s2 <= CH_UC_Z)
		|-> (mods_s2.shift != mods_s2.caps))
		else $error("upper-case letter without a single active modifier");

	// a release byte yields no character
	a_release_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && code_s1 >= SC_REL_LO && code_s1 <= SC_REL_HI)
		|=> (ascii_s2 == CH_NONE))
		else $error("release byte produced a character");

	// a shift press shows as held in its own result
	a_shift_press: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && (code_s1 == SC_LSHIFT || code_s1 == SC_RSHIFT))
		|=> (valid_s2 && mods_s2.shift))
		else $error("shift press not reflected in result");

	// a shift release shows as not held in its own result
	a_shift_release: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && (code_s1 == (SC_LSHIFT | SC_BREAK) || code_s1 == (SC_RSHIFT | SC_BREAK)))
		|=> (valid_s2 && !mods_s2.shift))
		else $error("shift release not reflected in result");

endmodule
